>>> rtl/core/lpc_pkg.sv
// shared widths, reset values and result type of the lru page cache
package lpc_pkg;

   // default sizing of the cache store
   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_PAGE_BITS   = 32;

   // fixed field widths on the channels and the csr port
   localparam int PAGE_W = 32;
   localparam int OCC_W  = 5;
   localparam int TOT_W  = 32;
   localparam int CFG_W  = 5;

   localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);
   localparam logic [TOT_W-1:0] TOT_MAX   = {TOT_W{1'b1}};

   // one result transaction
   typedef struct packed {
      logic              hit;
      logic              evicted_valid;
      logic [PAGE_W-1:0] evicted_page;
      logic [OCC_W-1:0]  occupancy;
      logic [TOT_W-1:0]  hit_total;
      logic [TOT_W-1:0]  miss_total;
   } rsp_type;

endpackage

>>> rtl/core/lpc_req_if.sv
// request and response channel interfaces of the lru page cache
interface lpc_req_if import lpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lpc_rsp_if import lpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              hit;
   logic              evicted_valid;
   logic [PAGE_W-1:0] evicted_page;
   logic [OCC_W-1:0]  occupancy;
   logic [TOT_W-1:0]  hit_total;
   logic [TOT_W-1:0]  miss_total;

   modport source (output valid, output hit, output evicted_valid, output evicted_page,
                   output occupancy, output hit_total, output miss_total, input ready);
   modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                   input occupancy, input hit_total, input miss_total, output ready);
endinterface

>>> rtl/core/lru_page_cache_simulator.sv
// top level of the fully associative lru page cache
//
// Usage: each request transaction on req_bus carries one page number. The
// page is compared against every held entry at once; a hit moves it to most
// recently used, a miss inserts it and, when the store holds csr capacity
// entries, first evicts the least recently used page. One response
// transaction on rsp_bus follows each request with hit/miss, the eviction,
// the occupancy and saturating hit and miss totals.
// Path: an accepted request waits in the input register; its response is
// loaded into the output register once that register is free or being drained.
// Throughput: one transaction per cycle while the response is not stalled,
// set by the combinational tag compare and recency shift that update the
// store as an item leaves the input reg.
// Stall: while rsp_bus.ready is low the response holds, the input register
// keeps one more request, and req_bus.ready then drops.
// csr_wr_en writes capacity (0 acts as 1, above MAX_ENTRIES acts as the
// maximum); write it only while no transaction is in flight.
// Reset (synchronous, active high) empties the store, clears both totals,
// sets capacity to 16 and drops both valids; no clearing pass is needed.
module lru_page_cache_simulator import lpc_pkg::*; #(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int PAGE_BITS   = DEF_PAGE_BITS
) (
   input  logic             clock,
   input  logic             reset,
   lpc_req_if.sink          req_bus,
   lpc_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   localparam int SLOT_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W     = (CNT_BITS > CFG_W) ? CNT_BITS : CFG_W;

   // configuration
   logic [CFG_W-1:0] capacity_ff;

   // store state
   logic [PAGE_BITS-1:0] entry_page_ff  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic [SLOT_BITS-1:0] order_ff [MAX_ENTRIES];
   logic [SLOT_BITS-1:0] order_in [MAX_ENTRIES];
   logic [CNT_BITS-1:0]  fill_ff, fill_in;
   logic [TOT_W-1:0]     hits_ff, hits_in, misses_ff, misses_in;

   // input and output registers
   logic                 in_valid_ff, in_valid_in;
   logic [PAGE_BITS-1:0] in_page_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   // lookup and update signals
   logic                 adv;
   logic [MAX_ENTRIES-1:0] slot_match, pos_hit;
   logic                 hit;
   logic [SLOT_BITS-1:0] hit_pos, move_pos, moved_slot, write_slot, insert_slot;
   logic [CNT_BITS-1:0]  move_last;
   logic [CMP_W-1:0]     cap_ext, cap_eff;
   logic                 evict, move_en, write_en;

   // handshake: the input register drains whenever the output can take a result
   assign adv             = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready   = !in_valid_ff || adv;
   assign in_valid_in     = (req_bus.valid && req_bus.ready) ? 1'b1 :
                            (adv ? 1'b0 : in_valid_ff);
   assign out_valid_in    = adv ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   // effective capacity, clamped to 1..MAX_ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         cap_eff = CMP_W'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   // parallel tag compare, then map the matching slot to its recency position
   always_comb begin
      hit_pos = '0;
      for (int s = 0; s < MAX_ENTRIES; s++) begin
         slot_match[s] = entry_valid_ff[s] && (entry_page_ff[s] == in_page_ff);
      end
      for (int p = 0; p < MAX_ENTRIES; p++) begin
         pos_hit[p] = (CNT_BITS'(p) < fill_ff) && slot_match[order_ff[p]];
         if (pos_hit[p]) begin
            hit_pos = hit_pos | SLOT_BITS'(p);
         end
      end
      hit = |pos_hit;
   end

   // replacement decision
   always_comb begin
      evict       = !hit && (CMP_W'(fill_ff) >= cap_eff);
      move_en     = adv && (hit || evict);
      move_pos    = hit ? hit_pos : '0;
      moved_slot  = order_ff[move_pos];
      move_last   = fill_ff - CNT_BITS'(1);
      insert_slot = order_ff[fill_ff[SLOT_BITS-1:0]];
      write_slot  = evict ? order_ff[0] : insert_slot;
      write_en    = adv && !hit;
   end

   // recency list shift: close the gap at move_pos, moved slot goes to the top
   always_comb begin
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         order_in[k] = order_ff[k];
         if (move_en) begin
            if (CNT_BITS'(k) == move_last) begin
               order_in[k] = moved_slot;
            end else if ((CNT_BITS'(k) >= CNT_BITS'(move_pos)) &&
                         (CNT_BITS'(k) < move_last)) begin
               if (k < MAX_ENTRIES - 1) begin
                  order_in[k] = order_ff[k + 1];
               end
            end
         end
      end
   end

   // fill level, valid bits and saturating totals
   always_comb begin
      fill_in        = fill_ff;
      entry_valid_in = entry_valid_ff;
      hits_in        = hits_ff;
      misses_in      = misses_ff;
      if (write_en) begin
         entry_valid_in[write_slot] = 1'b1;
         if (!evict) begin
            fill_in = fill_ff + CNT_BITS'(1);
         end
         if (misses_ff != TOT_MAX) begin
            misses_in = misses_ff + TOT_W'(1);
         end
      end
      if (adv && hit && (hits_ff != TOT_MAX)) begin
         hits_in = hits_ff + TOT_W'(1);
      end
   end

   // result assembly
   always_comb begin
      out_in.hit           = hit;
      out_in.evicted_valid = evict;
      out_in.evicted_page  = evict ? PAGE_W'(entry_page_ff[order_ff[0]]) : '0;
      out_in.occupancy     = OCC_W'(fill_in);
      out_in.hit_total     = hits_in;
      out_in.miss_total    = misses_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAP_RESET;
         entry_valid_ff <= '0;
         fill_ff        <= '0;
         hits_ff        <= '0;
         misses_ff      <= '0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         for (int k = 0; k < MAX_ENTRIES; k++) begin
            order_ff[k] <= SLOT_BITS'(k);
         end
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         entry_valid_ff <= entry_valid_in;
         fill_ff        <= fill_in;
         hits_ff        <= hits_in;
         misses_ff      <= misses_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         order_ff       <= order_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_page_ff <= PAGE_BITS'(req_bus.page_number);
      end
      if (adv) begin
         out_ff <= out_in;
      end
      if (write_en) begin
         entry_page_ff[write_slot] <= in_page_ff;
      end
   end

   // response channel
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.hit           = out_ff.hit;
   assign rsp_bus.evicted_valid = out_ff.evicted_valid;
   assign rsp_bus.evicted_page  = out_ff.evicted_page;
   assign rsp_bus.occupancy     = out_ff.occupancy;
   assign rsp_bus.hit_total     = out_ff.hit_total;
   assign rsp_bus.miss_total    = out_ff.miss_total;

   // occupancy tracks the valid bits
   a_fill_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(entry_valid_ff) == 32'(fill_ff))
      else $error("fill level differs from number of valid entries");

   // a held page appears at one recency position only
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pos_hit))
      else $error("page found at more than one position");

   // a hit never reports an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.hit && out_ff.evicted_valid))
      else $error("eviction reported on a hit");

   // a miss below saturation bumps the miss total by one
   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      (adv && !hit && (misses_ff != TOT_MAX)) |=> (misses_ff == $past(misses_ff) + TOT_W'(1)))
      else $error("miss total did not advance");

   // fill level never passes the store depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_ENTRIES)
      else $error("fill level above store depth");

endmodule
